/* sv/tcse_pkg.sv */
`timescale 1ns / 1ps

package tcse_pkg;

   // Fixed field widths
   localparam int STEP_BITS      = 24;
   localparam int INTERVAL_BITS  = 31;
   localparam int COUNT_BITS     = 25;
   localparam int LEVEL_BITS     = STEP_BITS + INTERVAL_BITS;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 32;

   // Register map
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_LEVEL_INTERVAL = 2'd0,
      CSR_LOWEST_STEP    = 2'd1,
      CSR_HIGHEST_STEP   = 2'd2,
      CSR_VERTEX_COUNT   = 2'd3
   } csr_index_type;

   // Front: checks the triangle and works out the range of crossing steps
   typedef enum logic [2:0] {
      FE_IDLE,
      FE_CHECK,
      FE_DIV_MIN,
      FE_SAVE_MIN,
      FE_DIV_MAX,
      FE_PLAN,
      FE_TRIM,
      FE_PUSH
   } front_state_type;

   // Back: walks the levels and interpolates the crossings
   typedef enum logic [2:0] {
      BE_IDLE,
      BE_LEVEL,
      BE_CLASS,
      BE_CROSS,
      BE_WAIT,
      BE_OUT
   } back_state_type;

   // Serial multiply then divide
   typedef enum logic [1:0] {
      MD_IDLE,
      MD_MUL,
      MD_DIV,
      MD_ROUND
   } md_state_type;

endpackage

/* sv/tin_contour_segment_extractor.sv */
`timescale 1ns / 1ps
// Front: per triangle, two serial floor divisions of the elevation extremes by the interval,
// one bit a cycle; a triangle dropped at the check skips them. A two-entry queue follows.
// Back: per segment the level, class and output states, plus for each of its four coordinates
// an interpolation (serial multiply then divide) or a snap.
// The back's multiply-divide unit sets throughput unless the output stalls; the first result follows
// the front, the queue and one segment. Synchronous reset clears control; registers to defaults.

module tin_contour_segment_extractor #(
   parameter int COORD_BITS     = 32,
   parameter int VERTEX_ID_BITS = 24,
   parameter int MAX_SEGMENTS   = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [tcse_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [tcse_pkg::CSR_DATA_BITS-1:0]    csr_data,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [VERTEX_ID_BITS-1:0]             req_vertex0_id,
   input  logic [VERTEX_ID_BITS-1:0]             req_vertex1_id,
   input  logic [VERTEX_ID_BITS-1:0]             req_vertex2_id,
   input  logic signed [COORD_BITS-1:0]          req_vertex0_x,
   input  logic signed [COORD_BITS-1:0]          req_vertex0_y,
   input  logic signed [COORD_BITS-1:0]          req_vertex0_z,
   input  logic signed [COORD_BITS-1:0]          req_vertex1_x,
   input  logic signed [COORD_BITS-1:0]          req_vertex1_y,
   input  logic signed [COORD_BITS-1:0]          req_vertex1_z,
   input  logic signed [COORD_BITS-1:0]          req_vertex2_x,
   input  logic signed [COORD_BITS-1:0]          req_vertex2_y,
   input  logic signed [COORD_BITS-1:0]          req_vertex2_z,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [tcse_pkg::STEP_BITS-1:0] rsp_level_step,
   output logic signed [COORD_BITS-1:0]          rsp_level_value,
   output logic signed [COORD_BITS-1:0]          rsp_start_x,
   output logic signed [COORD_BITS-1:0]          rsp_start_y,
   output logic signed [COORD_BITS-1:0]          rsp_end_x,
   output logic signed [COORD_BITS-1:0]          rsp_end_y,
   output logic [VERTEX_ID_BITS-1:0]             rsp_start_edge_low,
   output logic [VERTEX_ID_BITS-1:0]             rsp_start_edge_high,
   output logic [VERTEX_ID_BITS-1:0]             rsp_end_edge_low,
   output logic [VERTEX_ID_BITS-1:0]             rsp_end_edge_high,
   output logic                                  rsp_truncated,
   output logic                                  rsp_last
);

   localparam int SB = tcse_pkg::STEP_BITS;
   localparam int IB = tcse_pkg::INTERVAL_BITS;
   localparam int NB = tcse_pkg::COUNT_BITS;
   localparam int JW = 3*VERTEX_ID_BITS + 9*COORD_BITS + 2*SB + 1;

   logic [IB-1:0] interval_ff, interval_in;
   logic [SB-1:0] lowest_ff, lowest_in;
   logic [SB-1:0] highest_ff, highest_in;
   logic [NB-1:0] vcount_ff, vcount_in;

   logic          fq_valid, fq_ready, qb_valid, qb_ready;
   logic [JW-1:0] fq_data, qb_data;

   // Register writes
   assign csr_ready = 1'b1;

   always_comb begin
      interval_in = interval_ff;
      lowest_in   = lowest_ff;
      highest_in  = highest_ff;
      vcount_in   = vcount_ff;
      if (csr_valid) begin
         case (tcse_pkg::csr_index_type'(csr_index))
            tcse_pkg::CSR_LEVEL_INTERVAL: interval_in = csr_data[IB-1:0];
            tcse_pkg::CSR_LOWEST_STEP:    lowest_in   = csr_data[SB-1:0];
            tcse_pkg::CSR_HIGHEST_STEP:   highest_in  = csr_data[SB-1:0];
            tcse_pkg::CSR_VERTEX_COUNT:   vcount_in   = csr_data[NB-1:0];
            default:                      interval_in = interval_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= IB'(256);
         lowest_ff   <= '0;
         highest_ff  <= '0;
         vcount_ff   <= '0;
      end else begin
         interval_ff <= interval_in;
         lowest_ff   <= lowest_in;
         highest_ff  <= highest_in;
         vcount_ff   <= vcount_in;
      end
   end

   tcse_front #(
      .CW (COORD_BITS),
      .VB (VERTEX_ID_BITS),
      .MS (MAX_SEGMENTS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_ids        ({req_vertex2_id, req_vertex1_id, req_vertex0_id}),
      .req_coords     ({req_vertex2_z, req_vertex2_y, req_vertex2_x,
                        req_vertex1_z, req_vertex1_y, req_vertex1_x,
                        req_vertex0_z, req_vertex0_y, req_vertex0_x}),
      .level_interval (interval_ff),
      .lowest_step    (lowest_ff),
      .highest_step   (highest_ff),
      .vertex_count   (vcount_ff),
      .job_valid      (fq_valid),
      .job_ready      (fq_ready),
      .job_data       (fq_data)
   );

   tcse_queue #(
      .WIDTH (JW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  (fq_data),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_data   (qb_data)
   );

   tcse_back #(
      .CW (COORD_BITS),
      .VB (VERTEX_ID_BITS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .job_valid           (qb_valid),
      .job_ready           (qb_ready),
      .job_data            (qb_data),
      .level_interval      (interval_ff),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_level_step      (rsp_level_step),
      .rsp_level_value     (rsp_level_value),
      .rsp_start_x         (rsp_start_x),
      .rsp_start_y         (rsp_start_y),
      .rsp_end_x           (rsp_end_x),
      .rsp_end_y           (rsp_end_y),
      .rsp_start_edge_low  (rsp_start_edge_low),
      .rsp_start_edge_high (rsp_start_edge_high),
      .rsp_end_edge_low    (rsp_end_edge_low),
      .rsp_end_edge_high   (rsp_end_edge_high),
      .rsp_truncated       (rsp_truncated),
      .rsp_last            (rsp_last)
   );

endmodule

/* sv/tcse_queue.sv */
`timescale 1ns / 1ps

module tcse_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed transaction
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* sv/tcse_front.sv */
`timescale 1ns / 1ps

module tcse_front #(
   parameter int CW = 32,
   parameter int VB = 24,
   parameter int MS = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [3*VB-1:0]                      req_ids,
   input  logic [9*CW-1:0]                      req_coords,
   input  logic [tcse_pkg::INTERVAL_BITS-1:0]   level_interval,
   input  logic [tcse_pkg::STEP_BITS-1:0]       lowest_step,
   input  logic [tcse_pkg::STEP_BITS-1:0]       highest_step,
   input  logic [tcse_pkg::COUNT_BITS-1:0]      vertex_count,
   output logic                                 job_valid,
   input  logic                                 job_ready,
   output logic [3*VB+9*CW+2*tcse_pkg::STEP_BITS:0] job_data
);

   localparam int IB   = tcse_pkg::INTERVAL_BITS;
   localparam int SB   = tcse_pkg::STEP_BITS;
   localparam int FW   = ((CW > SB) ? CW : SB) + 2;
   localparam int IDW  = (VB > tcse_pkg::COUNT_BITS) ? VB : tcse_pkg::COUNT_BITS;
   localparam int CNTW = $clog2(CW);

   tcse_pkg::front_state_type state_ff, state_in;

   logic [3*VB-1:0]       ids_ff, ids_in;
   logic [9*CW-1:0]       coords_ff, coords_in;
   logic [CW-1:0]         dvd_ff, dvd_in;
   logic [IB-1:0]         rem_ff, rem_in;
   logic [CNTW-1:0]       cnt_ff, cnt_in;
   logic                  neg_ff, neg_in;
   logic signed [FW-1:0]  fmin_ff, fmin_in;
   logic signed [FW-1:0]  first_ff, first_in;
   logic signed [FW-1:0]  last_ff, last_in;
   logic [SB-1:0]         fin_ff, fin_in;
   logic                  trunc_ff, trunc_in;

   logic signed [CW-1:0]  z0, z1, z2, zmin, zmax;
   logic [CW-1:0]         zmin_mag, zmax_mag;
   logic [IB:0]           trial;
   logic                  ge;
   logic [FW-1:0]         uq_ext;
   logic signed [FW-1:0]  floor_val;
   logic signed [FW-1:0]  lo_ext, hi_ext, cand_first, span;
   logic                  ids_ok, cfg_ok;

   // Elevations and their extremes
   assign z0 = coords_ff[2*CW +: CW];
   assign z1 = coords_ff[5*CW +: CW];
   assign z2 = coords_ff[8*CW +: CW];

   always_comb begin
      zmin = z0;
      zmax = z0;
      if (z1 < zmin) zmin = z1;
      if (z2 < zmin) zmin = z2;
      if (z1 > zmax) zmax = z1;
      if (z2 > zmax) zmax = z2;
   end

   assign zmin_mag = zmin[CW-1] ? (~zmin + CW'(1)) : zmin;
   assign zmax_mag = zmax[CW-1] ? (~zmax + CW'(1)) : zmax;

   // Screen ids and configuration
   assign ids_ok = (IDW'(ids_ff[0 +: VB]) < IDW'(vertex_count)) &&
                   (IDW'(ids_ff[VB +: VB]) < IDW'(vertex_count)) &&
                   (IDW'(ids_ff[2*VB +: VB]) < IDW'(vertex_count));
   assign cfg_ok = (level_interval != '0) &&
                   ($signed(lowest_step) <= $signed(highest_step));

   // One restoring division step
   assign trial = {rem_ff, dvd_ff[CW-1]};
   assign ge    = (trial >= {1'b0, level_interval});

   // Floor of the finished quotient
   assign uq_ext    = {{(FW-CW){1'b0}}, dvd_ff};
   assign floor_val = neg_ff ? $signed(-uq_ext - FW'(rem_ff != '0)) : $signed(uq_ext);

   assign lo_ext     = {{(FW-SB){lowest_step[SB-1]}}, lowest_step};
   assign hi_ext     = {{(FW-SB){highest_step[SB-1]}}, highest_step};
   assign cand_first = fmin_ff + FW'(1);
   assign span       = last_ff - first_ff;

   assign req_ready = (state_ff == tcse_pkg::FE_IDLE);
   assign job_valid = (state_ff == tcse_pkg::FE_PUSH);
   assign job_data  = {trunc_ff, fin_ff, first_ff[SB-1:0], coords_ff, ids_ff};

   always_comb begin
      state_in  = state_ff;
      ids_in    = ids_ff;
      coords_in = coords_ff;
      dvd_in    = dvd_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      neg_in    = neg_ff;
      fmin_in   = fmin_ff;
      first_in  = first_ff;
      last_in   = last_ff;
      fin_in    = fin_ff;
      trunc_in  = trunc_ff;
      case (state_ff)
         tcse_pkg::FE_IDLE: begin
            if (req_valid) begin
               ids_in    = req_ids;
               coords_in = req_coords;
               state_in  = tcse_pkg::FE_CHECK;
            end
         end
         tcse_pkg::FE_CHECK: begin
            // Drop malformed triangles, a zero interval or an empty level range
            if (ids_ok && cfg_ok) begin
               dvd_in   = zmin_mag;
               neg_in   = zmin[CW-1];
               rem_in   = '0;
               cnt_in   = '0;
               state_in = tcse_pkg::FE_DIV_MIN;
            end else begin
               state_in = tcse_pkg::FE_IDLE;
            end
         end
         tcse_pkg::FE_DIV_MIN, tcse_pkg::FE_DIV_MAX: begin
            rem_in = ge ? IB'(trial - {1'b0, level_interval}) : trial[IB-1:0];
            dvd_in = {dvd_ff[CW-2:0], ge};
            cnt_in = cnt_ff + CNTW'(1);
            if (cnt_ff == CNTW'(CW - 1)) begin
               state_in = (state_ff == tcse_pkg::FE_DIV_MIN) ? tcse_pkg::FE_SAVE_MIN
                                                             : tcse_pkg::FE_PLAN;
            end
         end
         tcse_pkg::FE_SAVE_MIN: begin
            fmin_in  = floor_val;
            dvd_in   = zmax_mag;
            neg_in   = zmax[CW-1];
            rem_in   = '0;
            cnt_in   = '0;
            state_in = tcse_pkg::FE_DIV_MAX;
         end
         tcse_pkg::FE_PLAN: begin
            // Clamp to the configured step range
            first_in = (cand_first < lo_ext) ? lo_ext : cand_first;
            last_in  = (floor_val > hi_ext) ? hi_ext : floor_val;
            state_in = tcse_pkg::FE_TRIM;
         end
         tcse_pkg::FE_TRIM: begin
            if (last_ff < first_ff) begin
               state_in = tcse_pkg::FE_IDLE;
            end else begin
               trunc_in = (span > $signed(FW'(MS - 1)));
               fin_in   = trunc_in ? SB'(first_ff + FW'(MS - 1)) : last_ff[SB-1:0];
               state_in = tcse_pkg::FE_PUSH;
            end
         end
         tcse_pkg::FE_PUSH: begin
            if (job_ready) begin
               state_in = tcse_pkg::FE_IDLE;
            end
         end
         default: begin
            state_in = tcse_pkg::FE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tcse_pkg::FE_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      ids_ff    <= ids_in;
      coords_ff <= coords_in;
      dvd_ff    <= dvd_in;
      rem_ff    <= rem_in;
      neg_ff    <= neg_in;
      fmin_ff   <= fmin_in;
      first_ff  <= first_in;
      last_ff   <= last_in;
      fin_ff    <= fin_in;
      trunc_ff  <= trunc_in;
   end

endmodule

/* sv/tcse_muldiv.sv */
`timescale 1ns / 1ps

module tcse_muldiv #(
   parameter int DW = 33
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] mag,
   input  logic [DW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          done,
   output logic [DW-1:0] quo
);

   localparam int CNTW = $clog2(DW);

   tcse_pkg::md_state_type state_ff, state_in;

   logic [DW-1:0]   mag_ff, mag_in;
   logic [DW-1:0]   num_ff, num_in;
   logic [DW-1:0]   den_ff, den_in;
   logic [2*DW-1:0] prod_ff, prod_in;
   logic [DW-1:0]   rem_ff, rem_in;
   logic [DW-1:0]   quo_ff, quo_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;

   logic [2*DW-1:0] prod_step;
   logic [DW:0]     trial;
   logic            ge;
   logic            round_up;

   // Shift-and-add, most significant multiplier bit first
   assign prod_step = {prod_ff[2*DW-2:0], 1'b0} +
                      (num_ff[DW-1] ? {{DW{1'b0}}, mag_ff} : '0);

   // Restoring division over the low product bits
   assign trial    = {rem_ff, prod_ff[DW-1]};
   assign ge       = (trial >= {1'b0, den_ff});
   assign round_up = ({rem_ff, 1'b0} >= {1'b0, den_ff});

   assign done = (state_ff == tcse_pkg::MD_ROUND);
   assign quo  = quo_ff + DW'(round_up);

   always_comb begin
      state_in = state_ff;
      mag_in   = mag_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         tcse_pkg::MD_IDLE: begin
            if (start) begin
               mag_in   = mag;
               num_in   = num;
               den_in   = den;
               prod_in  = '0;
               cnt_in   = '0;
               state_in = tcse_pkg::MD_MUL;
            end
         end
         tcse_pkg::MD_MUL: begin
            prod_in = prod_step;
            num_in  = {num_ff[DW-2:0], 1'b0};
            cnt_in  = cnt_ff + CNTW'(1);
            if (cnt_ff == CNTW'(DW - 1)) begin
               rem_in   = prod_step[2*DW-1:DW];
               cnt_in   = '0;
               state_in = tcse_pkg::MD_DIV;
            end
         end
         tcse_pkg::MD_DIV: begin
            rem_in  = ge ? DW'(trial - {1'b0, den_ff}) : trial[DW-1:0];
            quo_in  = {quo_ff[DW-2:0], ge};
            prod_in = {prod_ff[2*DW-2:0], 1'b0};
            cnt_in  = cnt_ff + CNTW'(1);
            if (cnt_ff == CNTW'(DW - 1)) begin
               state_in = tcse_pkg::MD_ROUND;
            end
         end
         tcse_pkg::MD_ROUND: begin
            state_in = tcse_pkg::MD_IDLE;
         end
         default: begin
            state_in = tcse_pkg::MD_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tcse_pkg::MD_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
   end

endmodule

/* sv/tcse_back.sv */
`timescale 1ns / 1ps

module tcse_back #(
   parameter int CW = 32,
   parameter int VB = 24
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     job_valid,
   output logic                                     job_ready,
   input  logic [3*VB+9*CW+2*tcse_pkg::STEP_BITS:0] job_data,
   input  logic [tcse_pkg::INTERVAL_BITS-1:0]       level_interval,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [tcse_pkg::STEP_BITS-1:0]    rsp_level_step,
   output logic signed [CW-1:0]                     rsp_level_value,
   output logic signed [CW-1:0]                     rsp_start_x,
   output logic signed [CW-1:0]                     rsp_start_y,
   output logic signed [CW-1:0]                     rsp_end_x,
   output logic signed [CW-1:0]                     rsp_end_y,
   output logic [VB-1:0]                            rsp_start_edge_low,
   output logic [VB-1:0]                            rsp_start_edge_high,
   output logic [VB-1:0]                            rsp_end_edge_low,
   output logic [VB-1:0]                            rsp_end_edge_high,
   output logic                                     rsp_truncated,
   output logic                                     rsp_last
);

   localparam int SB = tcse_pkg::STEP_BITS;
   localparam int LB = tcse_pkg::LEVEL_BITS;
   localparam int DW = CW + 1;
   localparam int VW = 3 * CW;

   tcse_pkg::back_state_type state_ff, state_in;

   logic [3*VB-1:0]      ids_ff, ids_in;
   logic [9*CW-1:0]      coords_ff, coords_in;
   logic signed [SB-1:0] cur_ff, cur_in;
   logic [SB-1:0]        fin_ff, fin_in;
   logic                 trunc_ff, trunc_in;
   logic signed [LB-1:0] level_ff, level_in;
   logic [VW-1:0]        cb_ff [2];
   logic [VW-1:0]        cb_in [2];
   logic [VW-1:0]        ca_ff [2];
   logic [VW-1:0]        ca_in [2];
   logic [VB-1:0]        elo_ff [2];
   logic [VB-1:0]        elo_in [2];
   logic [VB-1:0]        ehi_ff [2];
   logic [VB-1:0]        ehi_in [2];
   logic [CW-1:0]        res_ff [4];
   logic [CW-1:0]        res_in [4];
   logic [1:0]           k_ff, k_in;
   logic                 neg_ff, neg_in;

   logic signed [LB:0]   lvl_prod;
   logic [2:0]           above;
   logic [1:0]           lone, o0, o1;
   logic [1:0]           vb_sel [2];
   logic [1:0]           va_sel [2];
   logic                 one_above;
   logic                 j, c;
   logic signed [CW-1:0] a_c, b_c, za, zb;
   logic signed [DW-1:0] diff_ab, den_w, sum_w;
   logic [DW-1:0]        mag_w;
   logic signed [LB-1:0] num_w;
   logic                 snap;
   logic                 md_start, md_done;
   logic [DW-1:0]        md_quo;

   function automatic logic [VW-1:0] vtx(input logic [1:0] idx, input logic [9*CW-1:0] cs);
      logic [VW-1:0] v;
      case (idx)
         2'd0:    v = cs[0 +: VW];
         2'd1:    v = cs[VW +: VW];
         default: v = cs[2*VW +: VW];
      endcase
      return v;
   endfunction

   function automatic logic [VB-1:0] vid(input logic [1:0] idx, input logic [3*VB-1:0] is);
      logic [VB-1:0] v;
      case (idx)
         2'd0:    v = is[0 +: VB];
         2'd1:    v = is[VB +: VB];
         default: v = is[2*VB +: VB];
      endcase
      return v;
   endfunction

   // Level for the current step
   assign lvl_prod = $signed(cur_ff) * $signed({1'b0, level_interval});

   // Which vertices sit on or above the level
   assign above[0] = ($signed({{(LB-CW){coords_ff[3*CW-1]}}, coords_ff[2*CW +: CW]})
                      >= level_ff);
   assign above[1] = ($signed({{(LB-CW){coords_ff[6*CW-1]}}, coords_ff[5*CW +: CW]})
                      >= level_ff);
   assign above[2] = ($signed({{(LB-CW){coords_ff[9*CW-1]}}, coords_ff[8*CW +: CW]})
                      >= level_ff);
   assign one_above = ($countones(above) == 1);

   // Pick the lone vertex and both edges that meet there
   always_comb begin
      if (one_above) begin
         lone = above[0] ? 2'd0 : (above[1] ? 2'd1 : 2'd2);
      end else begin
         lone = !above[0] ? 2'd0 : (!above[1] ? 2'd1 : 2'd2);
      end
      case (lone)
         2'd0:    begin o0 = 2'd1; o1 = 2'd2; end
         2'd1:    begin o0 = 2'd2; o1 = 2'd0; end
         default: begin o0 = 2'd0; o1 = 2'd1; end
      endcase
      if (one_above) begin
         vb_sel[0] = o0;   va_sel[0] = lone;
         vb_sel[1] = o1;   va_sel[1] = lone;
      end else begin
         vb_sel[0] = lone; va_sel[0] = o0;
         vb_sel[1] = lone; va_sel[1] = o1;
      end
   end

   // Operands of the coordinate in hand
   assign j   = k_ff[1];
   assign c   = k_ff[0];
   assign a_c = c ? ca_ff[j][CW +: CW] : ca_ff[j][0 +: CW];
   assign b_c = c ? cb_ff[j][CW +: CW] : cb_ff[j][0 +: CW];
   assign za  = ca_ff[j][2*CW +: CW];
   assign zb  = cb_ff[j][2*CW +: CW];

   assign snap    = (level_ff >= $signed({{(LB-CW){za[CW-1]}}, za}));
   assign diff_ab = {a_c[CW-1], a_c} - {b_c[CW-1], b_c};
   assign mag_w   = diff_ab[DW-1] ? DW'(-diff_ab) : diff_ab;
   assign num_w   = level_ff - {{(LB-CW){zb[CW-1]}}, zb};
   assign den_w   = {za[CW-1], za} - {zb[CW-1], zb};
   assign sum_w   = neg_ff ? ({b_c[CW-1], b_c} - $signed(md_quo))
                           : ({b_c[CW-1], b_c} + $signed(md_quo));
   assign md_start = (state_ff == tcse_pkg::BE_CROSS) && !snap;

   tcse_muldiv #(
      .DW (DW)
   ) u_muldiv (
      .clock (clock),
      .reset (reset),
      .start (md_start),
      .mag   (mag_w),
      .num   (num_w[DW-1:0]),
      .den   (den_w),
      .done  (md_done),
      .quo   (md_quo)
   );

   assign job_ready = (state_ff == tcse_pkg::BE_IDLE);
   assign rsp_valid = (state_ff == tcse_pkg::BE_OUT);

   assign rsp_level_step      = cur_ff;
   assign rsp_level_value     = level_ff[CW-1:0];
   assign rsp_start_x         = res_ff[0];
   assign rsp_start_y         = res_ff[1];
   assign rsp_end_x           = res_ff[2];
   assign rsp_end_y           = res_ff[3];
   assign rsp_start_edge_low  = elo_ff[0];
   assign rsp_start_edge_high = ehi_ff[0];
   assign rsp_end_edge_low    = elo_ff[1];
   assign rsp_end_edge_high   = ehi_ff[1];
   assign rsp_truncated       = trunc_ff;
   assign rsp_last            = (cur_ff == fin_ff);

   always_comb begin
      logic [VB-1:0] idb;
      logic [VB-1:0] ida;
      state_in  = state_ff;
      ids_in    = ids_ff;
      coords_in = coords_ff;
      cur_in    = cur_ff;
      fin_in    = fin_ff;
      trunc_in  = trunc_ff;
      level_in  = level_ff;
      cb_in     = cb_ff;
      ca_in     = ca_ff;
      elo_in    = elo_ff;
      ehi_in    = ehi_ff;
      res_in    = res_ff;
      k_in      = k_ff;
      neg_in    = neg_ff;
      idb       = '0;
      ida       = '0;
      case (state_ff)
         tcse_pkg::BE_IDLE: begin
            if (job_valid) begin
               ids_in    = job_data[0 +: 3*VB];
               coords_in = job_data[3*VB +: 9*CW];
               cur_in    = job_data[3*VB+9*CW +: SB];
               fin_in    = job_data[3*VB+9*CW+SB +: SB];
               trunc_in  = job_data[3*VB+9*CW+2*SB];
               state_in  = tcse_pkg::BE_LEVEL;
            end
         end
         tcse_pkg::BE_LEVEL: begin
            level_in = lvl_prod[LB-1:0];
            state_in = tcse_pkg::BE_CLASS;
         end
         tcse_pkg::BE_CLASS: begin
            // Latch both edges and their id keys
            for (int e = 0; e < 2; e++) begin
               cb_in[e] = vtx(vb_sel[e], coords_ff);
               ca_in[e] = vtx(va_sel[e], coords_ff);
               idb      = vid(vb_sel[e], ids_ff);
               ida      = vid(va_sel[e], ids_ff);
               elo_in[e] = (idb < ida) ? idb : ida;
               ehi_in[e] = (idb < ida) ? ida : idb;
            end
            k_in     = 2'd0;
            state_in = tcse_pkg::BE_CROSS;
         end
         tcse_pkg::BE_CROSS: begin
            if (snap) begin
               res_in[k_ff] = a_c;
               k_in         = k_ff + 2'd1;
               state_in     = (k_ff == 2'd3) ? tcse_pkg::BE_OUT : tcse_pkg::BE_CROSS;
            end else begin
               neg_in   = diff_ab[DW-1];
               state_in = tcse_pkg::BE_WAIT;
            end
         end
         tcse_pkg::BE_WAIT: begin
            if (md_done) begin
               res_in[k_ff] = sum_w[CW-1:0];
               k_in         = k_ff + 2'd1;
               state_in     = (k_ff == 2'd3) ? tcse_pkg::BE_OUT : tcse_pkg::BE_CROSS;
            end
         end
         tcse_pkg::BE_OUT: begin
            // Hold the result until taken, then advance the level or, after the last, go idle
            if (rsp_ready) begin
               if (cur_ff == fin_ff) begin
                  state_in = tcse_pkg::BE_IDLE;
               end else begin
                  cur_in   = cur_ff + SB'(1);
                  state_in = tcse_pkg::BE_LEVEL;
               end
            end
         end
         default: begin
            state_in = tcse_pkg::BE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tcse_pkg::BE_IDLE;
         cur_ff   <= '0;
         fin_ff   <= '0;
         k_ff     <= 2'd0;
      end else begin
         state_ff <= state_in;
         cur_ff   <= cur_in;
         fin_ff   <= fin_in;
         k_ff     <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      ids_ff    <= ids_in;
      coords_ff <= coords_in;
      trunc_ff  <= trunc_in;
      level_ff  <= level_in;
      cb_ff     <= cb_in;
      ca_ff     <= ca_in;
      elo_ff    <= elo_in;
      ehi_ff    <= ehi_in;
      res_ff    <= res_in;
      neg_ff    <= neg_in;
   end

endmodule

/* tb/sv/tin_contour_segment_extractor_test.sv */
`timescale 1ns / 1ps

module tin_contour_segment_extractor_test;

   localparam int XB = 32;
   localparam int IB = 24;
   localparam int SB = tcse_pkg::STEP_BITS;
   localparam int MAXSEG = 64;
   localparam int SETTLE = 400;
   localparam int N_DIR = 18;

   typedef struct {
      logic [IB-1:0]        id[3];
      logic signed [XB-1:0] x[3];
      logic signed [XB-1:0] y[3];
      logic signed [XB-1:0] z[3];
      bit                   none;
   } triangle_type;

   typedef struct {
      logic signed [SB-1:0]        step;
      logic signed [XB-1:0]        level;
      logic signed [XB-1:0]        sx, sy, ex, ey;
      logic [IB-1:0]               sel, seh, eel, eeh;
      logic                        trunc, last;
   } segment_type;

   logic clock, reset;
   logic csr_valid, csr_ready;
   logic [tcse_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [tcse_pkg::CSR_DATA_BITS-1:0]  csr_data;
   logic req_valid, req_ready;
   logic [IB-1:0] req_vertex0_id, req_vertex1_id, req_vertex2_id;
   logic signed [XB-1:0] req_vertex0_x, req_vertex0_y, req_vertex0_z;
   logic signed [XB-1:0] req_vertex1_x, req_vertex1_y, req_vertex1_z;
   logic signed [XB-1:0] req_vertex2_x, req_vertex2_y, req_vertex2_z;
   logic rsp_valid, rsp_ready;
   logic signed [SB-1:0] rsp_level_step;
   logic signed [XB-1:0] rsp_level_value, rsp_start_x, rsp_start_y, rsp_end_x, rsp_end_y;
   logic [IB-1:0] rsp_start_edge_low, rsp_start_edge_high, rsp_end_edge_low, rsp_end_edge_high;
   logic rsp_truncated, rsp_last;

   // Current register contents as the predictor sees them
   longint lvl_interval, lvl_lowest, lvl_highest, vtx_count;

   segment_type pending_segments[$];
   int fails;
   int send_idle, recv_idle;
   logic rsp_hold;
   event start_hold;

   triangle_type dir_rows[N_DIR];
   int dir_cfg[N_DIR];

   tin_contour_segment_extractor uut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #400ms;
      $display("status: fail");
      $finish;
   end

   // (m * n) / d rounded to nearest, halves up
   function automatic logic [63:0] scale_round(logic [63:0] m, logic [63:0] n, logic [63:0] d);
      logic [127:0] p, q, r;
      p = {64'd0, m} * {64'd0, n};
      q = p / {64'd0, d};
      r = p % {64'd0, d};
      if ((r << 1) >= {64'd0, d}) q = q + 1;
      return q[63:0];
   endfunction

   function automatic longint floor_quot(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q = q - 1;
      return q;
   endfunction

   // Crossing on the edge from lower vertex b toward upper vertex a
   function automatic void edge_crossing(triangle_type t, int b, int a, longint lvl,
                                         output logic signed [XB-1:0] ox,
                                         output logic signed [XB-1:0] oy,
                                         output logic [IB-1:0] elo, output logic [IB-1:0] ehi);
      longint za, zb, dx, dy, bx, by;
      logic [63:0] qx, qy;
      za = longint'(t.z[a]);
      zb = longint'(t.z[b]);
      elo = (t.id[b] < t.id[a]) ? t.id[b] : t.id[a];
      ehi = (t.id[b] < t.id[a]) ? t.id[a] : t.id[b];
      if (lvl >= za) begin
         ox = t.x[a];
         oy = t.y[a];
      end else begin
         bx = longint'(t.x[b]);
         by = longint'(t.y[b]);
         dx = longint'(t.x[a]) - bx;
         dy = longint'(t.y[a]) - by;
         qx = scale_round(dx < 0 ? -dx : dx, lvl - zb, za - zb);
         qy = scale_round(dy < 0 ? -dy : dy, lvl - zb, za - zb);
         ox = XB'((dx < 0) ? bx - longint'(qx) : bx + longint'(qx));
         oy = XB'((dy < 0) ? by - longint'(qy) : by + longint'(qy));
      end
   endfunction

   // Work out every segment a triangle yields and queue them
   function automatic void predict_segments(triangle_type t);
      longint zmin, zmax, first, lastl, cnt, stp, lvl;
      bit trunc;
      bit ab[3];
      int nab, lone, o0, o1;
      segment_type s;
      for (int i = 0; i < 3; i++)
         if (longint'(t.id[i]) >= vtx_count) return;
      if (lvl_interval <= 0 || lvl_lowest > lvl_highest) return;
      zmin = longint'(t.z[0]);
      zmax = longint'(t.z[0]);
      for (int i = 1; i < 3; i++) begin
         if (longint'(t.z[i]) < zmin) zmin = longint'(t.z[i]);
         if (longint'(t.z[i]) > zmax) zmax = longint'(t.z[i]);
      end
      first = floor_quot(zmin, lvl_interval) + 1;
      lastl = floor_quot(zmax, lvl_interval);
      if (first < lvl_lowest) first = lvl_lowest;
      if (lastl > lvl_highest) lastl = lvl_highest;
      if (lastl < first) return;
      cnt = lastl - first + 1;
      trunc = cnt > MAXSEG;
      if (trunc) cnt = MAXSEG;
      for (stp = first; stp <= first + cnt - 1; stp++) begin
         lvl = stp * lvl_interval;
         nab = 0;
         for (int i = 0; i < 3; i++) begin
            ab[i] = longint'(t.z[i]) >= lvl;
            nab += int'(ab[i]);
         end
         if (nab == 1) lone = ab[0] ? 0 : (ab[1] ? 1 : 2);
         else lone = !ab[0] ? 0 : (!ab[1] ? 1 : 2);
         o0 = (lone + 1) % 3;
         o1 = (lone + 2) % 3;
         s.step = SB'(stp);
         s.level = XB'(lvl);
         if (nab == 1) begin
            edge_crossing(t, o0, lone, lvl, s.sx, s.sy, s.sel, s.seh);
            edge_crossing(t, o1, lone, lvl, s.ex, s.ey, s.eel, s.eeh);
         end else begin
            edge_crossing(t, lone, o0, lvl, s.sx, s.sy, s.sel, s.seh);
            edge_crossing(t, lone, o1, lvl, s.ex, s.ey, s.eel, s.eeh);
         end
         s.trunc = trunc;
         s.last = (stp == first + cnt - 1);
         pending_segments = {pending_segments, s};
      end
   endfunction

   task automatic field_check(string name, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
         $error("%s: expected %0h, got %0h", name, e, a);
         fails++;
      end
   endtask

   // Receive side: check each transaction, then decide ready for the next cycle
   always @(posedge clock) begin
      segment_type s;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_segments.size() == 0) begin
               $error("segment arrived with none outstanding");
               fails++;
            end else begin
               s = pending_segments.pop_front();
               field_check("level_step", s.step, rsp_level_step);
               field_check("level_value", s.level, rsp_level_value);
               field_check("start_x", s.sx, rsp_start_x);
               field_check("start_y", s.sy, rsp_start_y);
               field_check("end_x", s.ex, rsp_end_x);
               field_check("end_y", s.ey, rsp_end_y);
               field_check("start_edge_low", s.sel, rsp_start_edge_low);
               field_check("start_edge_high", s.seh, rsp_start_edge_high);
               field_check("end_edge_low", s.eel, rsp_end_edge_low);
               field_check("end_edge_high", s.eeh, rsp_end_edge_high);
               field_check("truncated", s.trunc, rsp_truncated);
               field_check("last", s.last, rsp_last);
            end
         end
         rsp_ready <= !rsp_hold && ($urandom_range(0, 99) >= recv_idle);
      end
   end

   // Long receiver hold-off, counted here
   initial begin
      rsp_hold = 1'b0;
      forever begin
         @(start_hold);
         rsp_hold <= 1'b1;
         repeat (3000) @(posedge clock);
         rsp_hold <= 1'b0;
      end
   end

   task automatic csr_write(tcse_pkg::csr_index_type idx,
                            logic [tcse_pkg::CSR_DATA_BITS-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Hold until every segment is back and the block has settled
   task automatic drain_block();
      while (pending_segments.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_levels(longint iv, longint lo, longint hi, longint vc);
      drain_block();
      csr_write(tcse_pkg::CSR_LEVEL_INTERVAL, 32'(iv));
      csr_write(tcse_pkg::CSR_LOWEST_STEP, 32'(lo & 32'hFFFFFF));
      csr_write(tcse_pkg::CSR_HIGHEST_STEP, 32'(hi & 32'hFFFFFF));
      csr_write(tcse_pkg::CSR_VERTEX_COUNT, 32'(vc));
      lvl_interval = iv & 32'h7FFFFFFF;
      lvl_lowest = longint'(signed'(lo[SB-1:0]));
      lvl_highest = longint'(signed'(hi[SB-1:0]));
      vtx_count = vc & 32'h1FFFFFF;
   endtask

   task automatic send_triangle(triangle_type t);
      while ($urandom_range(0, 99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_vertex0_id <= t.id[0];
      req_vertex1_id <= t.id[1];
      req_vertex2_id <= t.id[2];
      req_vertex0_x <= t.x[0];
      req_vertex0_y <= t.y[0];
      req_vertex0_z <= t.z[0];
      req_vertex1_x <= t.x[1];
      req_vertex1_y <= t.y[1];
      req_vertex1_z <= t.z[1];
      req_vertex2_x <= t.x[2];
      req_vertex2_y <= t.y[2];
      req_vertex2_z <= t.z[2];
      do @(posedge clock); while (!req_ready);
      if (!t.none) predict_segments(t);
   endtask

   function automatic triangle_type mk_row(int i0, int i1, int i2,
                                           longint x0, longint y0, longint z0,
                                           longint x1, longint y1, longint z1,
                                           longint x2, longint y2, longint z2, bit none);
      triangle_type t;
      t.id[0] = IB'(i0); t.id[1] = IB'(i1); t.id[2] = IB'(i2);
      t.x[0] = XB'(x0); t.y[0] = XB'(y0); t.z[0] = XB'(z0);
      t.x[1] = XB'(x1); t.y[1] = XB'(y1); t.z[1] = XB'(z1);
      t.x[2] = XB'(x2); t.y[2] = XB'(y2); t.z[2] = XB'(z2);
      t.none = none;
      return t;
   endfunction

   // Random triangle: a narrow elevation span so few levels cross, mostly valid ids
   function automatic triangle_type random_triangle();
      triangle_type t;
      longint span, zb, lim, zv[3], iv;
      int k, r;
      iv = (lvl_interval > 0) ? lvl_interval : 1;
      k = $urandom_range(0, 3);
      span = k * iv + $urandom_range(0, (iv > 1000) ? 1000 : iv);
      if (span > 64'sd2147483648) span = 64'sd2147483648;
      if ($urandom_range(0, 1)) zb = lvl_lowest * iv - $urandom_range(0, 2 * iv);
      else zb = longint'(signed'($urandom()));
      lim = 64'sd2147483647 - span;
      if (zb < -64'sd2147483648) zb = -64'sd2147483648;
      if (zb > lim) zb = lim;
      zv[0] = zb;
      zv[1] = zb + span;
      zv[2] = zb + longint'($urandom_range(0, span));
      if ($urandom_range(0, 3) == 0) zv[2] = (zv[2] / iv) * iv;
      if ($urandom_range(0, 19) == 0) begin
         zv[1] = zb;
         zv[2] = zb;
      end
      r = $urandom_range(0, 2);
      for (int i = 0; i < 3; i++) begin
         t.z[i] = XB'(zv[(i + r) % 3]);
         t.x[i] = $urandom();
         t.y[i] = $urandom();
         if (vtx_count == 0) t.id[i] = IB'($urandom());
         else t.id[i] = IB'($urandom_range(0, vtx_count - 1));
      end
      if ($urandom_range(0, 9) == 0 && vtx_count < 64'd16777216)
         t.id[$urandom_range(0, 2)] = IB'($urandom_range(vtx_count, 24'hFFFFFF));
      t.none = 1'b0;
      return t;
   endfunction

   initial begin
      longint iv, lo, hi, vc;
      int sel, n;
      fails = 0;
      send_idle = 0;
      recv_idle = 0;
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = tcse_pkg::CSR_LEVEL_INTERVAL;
      csr_data = '0;
      req_valid = 1'b0;
      {req_vertex0_id, req_vertex1_id, req_vertex2_id} = '0;
      {req_vertex0_x, req_vertex0_y, req_vertex0_z} = '0;
      {req_vertex1_x, req_vertex1_y, req_vertex1_z} = '0;
      {req_vertex2_x, req_vertex2_y, req_vertex2_z} = '0;
      lvl_interval = 256;
      lvl_lowest = 0;
      lvl_highest = 0;
      vtx_count = 0;

      // Directed table: config set per row, 0 keeps the reset registers
      dir_cfg[0] = 0;
      dir_rows[0] = mk_row(0, 1, 2, 0, 0, 0, 10, 10, 1000, 20, 0, 500, 1);
      for (int i = 1; i <= 9; i++) dir_cfg[i] = 1;
      dir_rows[1] = mk_row(1, 2, 3, 0, 0, 0, 2560, 0, 0, 0, 2560, 1000, 0);
      dir_rows[2] = mk_row(3, 2, 1, 0, 0, 1000, 2560, 0, 1000, 0, 2560, 0, 0);
      dir_rows[3] = mk_row(4, 7, 9, -500, 300, 0, 700, -800, 512, 100, 900, 1024, 0);
      dir_rows[4] = mk_row(1, 2, 3, 5, 5, 512, 6, 6, 512, 7, 7, 512, 1);
      dir_rows[5] = mk_row(16, 2, 3, 0, 0, 0, 10, 10, 1000, 20, 0, 500, 1);
      dir_rows[6] = mk_row(5, 5, 5, 100, 200, -300, -100, 50, 900, 30, -70, 256, 0);
      dir_rows[7] = mk_row(15, 0, 8, 9, -9, -1000, 400, 11, -10, -33, 77, 300, 0);
      dir_rows[8] = mk_row(2, 14, 6, -64'sd2147483648, 2147483647, 0,
                           2147483647, -64'sd2147483648, 2000, 0, 0, 1000, 0);
      dir_rows[9] = mk_row(9, 3, 12, 2147483647, 2147483647, 3000,
                           -64'sd2147483648, -64'sd2147483648, -3000, 1, -1, 5, 0);
      dir_cfg[10] = 2;
      dir_rows[10] = mk_row(1, 2, 3, 0, 0, 0, 10, 10, 5000, 20, 0, 500, 1);
      dir_cfg[11] = 3;
      dir_rows[11] = mk_row(16777215, 0, 12345, 0, 0, -50, 1000, 1000, 50, -1000, 7, 20, 0);
      dir_cfg[12] = 3;
      dir_rows[12] = mk_row(0, 16777215, 7, -64'sd2147483648, 0, 3, 2147483647, -1, -3,
                            0, 5, 0, 0);
      dir_cfg[13] = 4;
      dir_rows[13] = mk_row(1, 2, 3, 1000, -1000, -64'sd2147483648, -1000, 1000, 2147483647,
                            0, 0, 0, 0);
      dir_cfg[14] = 4;
      dir_rows[14] = mk_row(7, 8, 9, 1, 2, -2147483647, 3, 4, -64'sd2147483648, 5, 6, 10, 0);
      dir_cfg[15] = 5;
      dir_rows[15] = mk_row(1, 2, 3, 0, 0, -5000, 10, 10, 5000, 20, 0, 0, 1);
      dir_cfg[16] = 6;
      dir_rows[16] = mk_row(4, 5, 6, -100, -100, -1, 100, -100, 0, 0, 100, 1, 0);
      dir_cfg[17] = 6;
      dir_rows[17] = mk_row(4, 5, 6, -100, -100, 1, 100, -100, 0, 0, 100, -1, 0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part
      for (int i = 0; i < N_DIR; i++) begin
         if (i > 0 && dir_cfg[i] != dir_cfg[i-1]) begin
            req_valid <= 1'b0;
            case (dir_cfg[i])
               1: set_levels(256, -100, 100, 16);
               2: set_levels(256, 5, 4, 16);
               3: set_levels(1, -8388608, 8388607, 16777216);
               4: set_levels(2147483647, -8388608, 8388607, 16777216);
               5: set_levels(0, -8388608, 8388607, 16777216);
               default: set_levels(256, 0, 0, 16777216);
            endcase
         end
         send_triangle(dir_rows[i]);
      end
      req_valid <= 1'b0;

      // Random part in phases of settings, idling pattern by progress
      n = 0;
      for (int ph = 0; ph < 9; ph++) begin
         sel = (ph == 0) ? 0 : $urandom_range(0, 4);
         case (sel)
            0: set_levels(256, -8388608, 8388607, 16777216);
            1: set_levels(2147483647, -8388608, 8388607, 1000);
            2: set_levels(1, -8388608, 8388607, 16777216);
            3: begin
               iv = (longint'(1) << $urandom_range(0, 30)) + $urandom_range(0, 255);
               if (iv > 2147483647) iv = 2147483647;
               lo = -longint'($urandom_range(0, 1 << 20));
               hi = ($urandom_range(0, 7) == 0) ? lo - 1 : longint'($urandom_range(0, 1 << 20));
               vc = $urandom_range(1, 16777216);
               set_levels(iv, lo, hi, vc);
            end
            default: set_levels(1000, 5, 5, 0);
         endcase
         for (int j = 0; j < 44; j++) begin
            if (n < 132) begin
               send_idle = 11;
               recv_idle = 88;
            end else if (n < 264) begin
               send_idle = 88;
               recv_idle = 11;
            end else begin
               send_idle = 0;
               recv_idle = 0;
            end
            if (ph == 0 && j == 10) -> start_hold;
            send_triangle(random_triangle());
            n++;
         end
         req_valid <= 1'b0;
      end

      drain_block();
      if (fails == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule

/* files.f */
sv/tcse_pkg.sv
sv/tcse_queue.sv
sv/tcse_front.sv
sv/tcse_muldiv.sv
sv/tcse_back.sv
sv/tin_contour_segment_extractor.sv
tb/sv/tin_contour_segment_extractor_test.sv
